>>> hdl/vbcs_pkg.sv
package vbcs_pkg;

	localparam int ATOM_COUNT = 1024;
	localparam int AW         = $clog2(ATOM_COUNT);
	localparam int FRAC_BITS  = 16;

	localparam longint ONE     = 64'sd1 <<< FRAC_BITS;
	localparam longint TOL_RAW = (ONE + 5000) / 10000;
	localparam longint TOL     = (TOL_RAW > 0) ? TOL_RAW : 1;
	localparam longint THR_RAW = (ONE + 500) / 1000;
	localparam longint THR     = (THR_RAW > 0) ? THR_RAW : 1;
	localparam longint TOL_SQ  = TOL * TOL;

	localparam int MW  = 48;
	localparam int DW  = 33 + FRAC_BITS;
	localparam int DFW = DW + 1;
	localparam int DCW = $clog2(DW + 1);

	localparam logic [2:0] CMD_WRITE  = 3'd0;
	localparam logic [2:0] CMD_READ   = 3'd1;
	localparam logic [2:0] CMD_INT    = 3'd2;
	localparam logic [2:0] CMD_SPRING = 3'd3;
	localparam logic [2:0] CMD_HARD   = 3'd4;

	localparam logic [1:0] REG_DT2     = 2'd0;
	localparam logic [1:0] REG_DAMP    = 2'd1;
	localparam logic [1:0] REG_SPR_EN  = 2'd2;
	localparam logic [1:0] REG_HARD_EN = 2'd3;

	localparam logic [4:0] ACT_NONE     = 5'd0;
	localparam logic [4:0] ACT_LATCH    = 5'd1;
	localparam logic [4:0] ACT_RD_A     = 5'd2;
	localparam logic [4:0] ACT_LD_A     = 5'd3;
	localparam logic [4:0] ACT_LD_B     = 5'd4;
	localparam logic [4:0] ACT_MUL_GO   = 5'd5;
	localparam logic [4:0] ACT_STEP     = 5'd6;
	localparam logic [4:0] ACT_SQ_ACC   = 5'd7;
	localparam logic [4:0] ACT_SQRT_GO  = 5'd8;
	localparam logic [4:0] ACT_DIV_GO   = 5'd9;
	localparam logic [4:0] ACT_DIV_TAKE = 5'd10;
	localparam logic [4:0] ACT_FAC_ONE  = 5'd11;
	localparam logic [4:0] ACT_TAKE_KD  = 5'd12;
	localparam logic [4:0] ACT_TAKE_S   = 5'd13;
	localparam logic [4:0] ACT_APPLY    = 5'd14;
	localparam logic [4:0] ACT_WORST    = 5'd15;
	localparam logic [4:0] ACT_WR_A     = 5'd16;
	localparam logic [4:0] ACT_WR_B     = 5'd17;
	localparam logic [4:0] ACT_OUT      = 5'd18;

	localparam logic [2:0] MOP_STEP  = 3'd0;
	localparam logic [2:0] MOP_SQ    = 3'd1;
	localparam logic [2:0] MOP_KD    = 3'd2;
	localparam logic [2:0] MOP_S     = 3'd3;
	localparam logic [2:0] MOP_FORCE = 3'd4;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [9:0]         atom_a;
		logic [9:0]         atom_b;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
		logic [30:0]        rest_length;
		logic [30:0]        stiffness;
		logic               restart_error;
	} item_t;

	typedef struct packed {
		logic [4:0] act;
		logic [1:0] lane;
		logic [2:0] mop;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       mul_busy;
		logic       sqrt_busy;
		logic       div_busy;
		logic       len_small;
		logic       rest_small;
		logic       hard_skip;
		logic       out_free;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -50'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

>>> hdl/vbcs_if.sv
interface vbcs_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [9:0]         atom_a;
	logic [9:0]         atom_b;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	logic [30:0]        rest_length;
	logic [30:0]        stiffness;
	logic               restart_error;

	modport source (output valid, cmd, atom_a, atom_b, in_x, in_y, in_z, rest_length,
		stiffness, restart_error, input ready);
	modport sink (input valid, cmd, atom_a, atom_b, in_x, in_y, in_z, rest_length,
		stiffness, restart_error, output ready);
endinterface

interface vbcs_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic [30:0]        max_error;
	logic               moved;

	modport source (output valid, out_x, out_y, out_z, max_error, moved, input ready);
	modport sink (input valid, out_x, out_y, out_z, max_error, moved, output ready);
endinterface

>>> hdl/vbcs_ram.sv
module vbcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/vbcs_dp.sv
module vbcs_dp import vbcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  item_t       item_d,
	input  dp_cmd_t     dc,
	output dp_sts_t     sts,
	vbcs_result_if.source result
);

	localparam logic [95:0]        PLIM   = 96'd1 << 62;
	localparam logic signed [63:0] HALF16 = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] HALF17 = 64'sd1 <<< FRAC_BITS;

	item_t              it_q;
	logic [30:0]        dt2_q;
	logic [16:0]        damp_q;
	logic               spr_en_q, hard_en_q;
	logic [30:0]        worst_q;
	logic signed [31:0] pa_q [3];
	logic signed [31:0] pb_q [3];
	logic signed [31:0] pv_q [3];
	logic signed [31:0] nx_q [3];
	logic signed [31:0] d_q  [3];
	logic [63:0]        acc_q;
	logic [MW-1:0]      ma_q, mb_q;
	logic               mneg_q, msh17_q;
	logic [1:0]         mcnt_q;
	logic [95:0]        p_q;
	logic [63:0]        sv_q, sr_q, sb_q;
	logic [5:0]         scnt_q;
	logic [DW-1:0]      dq_q;
	logic [31:0]        rem_q, dv_q;
	logic               dneg_q;
	logic [DCW-1:0]     dcnt_q;
	logic signed [DFW-1:0] fac_q;
	logic [MW-1:0]      kd_q;
	logic signed [MW-1:0] s_q;
	logic               moved_q;
	logic               ov_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic [30:0]        ome_q;
	logic               omv_q;

	logic               a_ok, b_ok;
	logic [2:0]         kind;
	logic [95:0]        cur_rd, prv_rd, cur_wd, prv_wd;
	logic [AW-1:0]      cur_ra, wa;
	logic               cur_we, prv_we;
	logic [31:0]        len;
	logic signed [32:0] dev;
	logic [32:0]        devmag;
	logic [30:0]        devsat;
	logic signed [32:0] sdiff, dnum;
	logic [32:0]        sdabs, dabs, nmag;
	logic [DFW-1:0]     fabs;
	logic [MW-1:0]      sabs;
	logic [MW-1:0]      op_a, op_b;
	logic               op_neg, op_sh17;
	logic [1:0]         cidx;
	logic [63:0]        pp;
	logic [62:0]        pcl;
	logic signed [63:0] vs, rnd, shr;
	logic signed [MW-1:0] mres;
	logic [63:0]        st;
	logic [32:0]        rsh;
	logic signed [31:0] nxv, dnv, na, nb, prv_n;
	logic               rest_int;
	logic signed [31:0] wa_x, wa_y, wa_z, wp_x, wp_y, wp_z;
	logic               out_load;

	assign a_ok = 32'(it_q.atom_a) < 32'(ATOM_COUNT);
	assign b_ok = 32'(it_q.atom_b) < 32'(ATOM_COUNT);

	always_comb begin
		kind = CMD_READ;
		if (a_ok) begin
			unique case (it_q.cmd)
				CMD_WRITE:  kind = CMD_WRITE;
				CMD_INT:    kind = CMD_INT;
				CMD_SPRING: if (b_ok && spr_en_q) kind = CMD_SPRING;
				CMD_HARD:   if (b_ok && hard_en_q) kind = CMD_HARD;
				default:    kind = CMD_READ;
			endcase
		end
	end

	assign len    = sr_q[31:0];
	assign dev    = $signed({1'b0, len}) - $signed({2'b0, it_q.rest_length});
	assign devmag = dev[32] ? 33'(-dev) : 33'(dev);
	assign devsat = (devmag > 33'h07fffffff) ? 31'h7fffffff : devmag[30:0];

	assign sdiff = 33'(pa_q[dc.lane]) - 33'(pv_q[dc.lane]);
	assign sdabs = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
	assign dabs  = d_q[dc.lane][31] ? 33'(-33'(d_q[dc.lane])) : 33'(d_q[dc.lane]);
	assign fabs  = fac_q[DFW-1] ? DFW'(-fac_q) : DFW'(fac_q);
	assign sabs  = s_q[MW-1] ? MW'(-s_q) : MW'(s_q);
	assign dnum  = (kind == CMD_HARD) ? dev : 33'(-dev);
	assign nmag  = dnum[32] ? 33'(-dnum) : 33'(dnum);

	always_comb begin
		op_a    = MW'(dabs);
		op_b    = MW'(dabs);
		op_neg  = 1'b0;
		op_sh17 = 1'b0;
		unique case (dc.mop)
			MOP_STEP: begin
				op_a   = MW'(sdabs);
				op_b   = MW'(damp_q);
				op_neg = sdiff[32];
			end
			MOP_SQ: begin
				op_a = MW'(dabs);
				op_b = MW'(dabs);
			end
			MOP_KD: begin
				op_a = MW'(it_q.stiffness);
				op_b = MW'(dt2_q);
			end
			MOP_S: begin
				op_a   = kd_q;
				op_b   = fabs[MW-1:0];
				op_neg = fac_q[DFW-1];
			end
			MOP_FORCE: begin
				op_a = MW'(dabs);
				if (kind == CMD_HARD) begin
					op_b    = fabs[MW-1:0];
					op_neg  = d_q[dc.lane][31] ^ fac_q[DFW-1];
					op_sh17 = 1'b1;
				end else begin
					op_b   = sabs;
					op_neg = d_q[dc.lane][31] ^ s_q[MW-1];
				end
			end
			default: op_neg = 1'b0;
		endcase
	end

	assign cidx = 2'd3 - mcnt_q;
	assign pp   = 64'(ma_q) * 64'(mb_q[16*cidx +: 16]);
	assign pcl  = (p_q > PLIM) ? PLIM[62:0] : p_q[62:0];
	assign vs   = mneg_q ? -$signed({1'b0, pcl}) : $signed({1'b0, pcl});
	assign rnd  = vs + (msh17_q ? HALF17 : HALF16);
	assign shr  = msh17_q ? (rnd >>> (FRAC_BITS + 1)) : (rnd >>> FRAC_BITS);
	assign mres = shr[MW-1:0];

	assign st  = sr_q + sb_q;
	assign rsh = {rem_q, dq_q[DW-1]};

	assign nxv = sat32(50'(pa_q[dc.lane]) + 50'(mres));
	assign dnv = sat32(50'(nxv) - 50'(pa_q[dc.lane]));
	assign na  = sat32(50'(pa_q[dc.lane]) + 50'(mres));
	assign nb  = sat32(50'(pb_q[dc.lane]) - 50'(mres));

	assign rest_int = acc_q < 64'(TOL_SQ);

	always_comb begin
		wa_x = pa_q[0];
		wa_y = pa_q[1];
		wa_z = pa_q[2];
		wp_x = pv_q[0];
		wp_y = pv_q[1];
		wp_z = pv_q[2];
		if (kind == CMD_WRITE) begin
			wa_x = it_q.in_x;
			wa_y = it_q.in_y;
			wa_z = it_q.in_z;
			wp_x = it_q.in_x;
			wp_y = it_q.in_y;
			wp_z = it_q.in_z;
		end else if (kind == CMD_INT) begin
			wa_x = nx_q[0];
			wa_y = nx_q[1];
			wa_z = nx_q[2];
			wp_x = rest_int ? nx_q[0] : pa_q[0];
			wp_y = rest_int ? nx_q[1] : pa_q[1];
			wp_z = rest_int ? nx_q[2] : pa_q[2];
		end
	end
	assign prv_n = wp_x;

	assign cur_ra = (dc.act == ACT_LD_A) ? AW'(it_q.atom_b) : AW'(it_q.atom_a);
	assign wa     = (dc.act == ACT_WR_B) ? AW'(it_q.atom_b) : AW'(it_q.atom_a);
	assign cur_we = (dc.act == ACT_WR_A) || (dc.act == ACT_WR_B);
	assign prv_we = (dc.act == ACT_WR_A) && ((kind == CMD_WRITE) || (kind == CMD_INT));
	assign cur_wd = (dc.act == ACT_WR_B) ? {pb_q[2], pb_q[1], pb_q[0]} : {wa_z, wa_y, wa_x};
	assign prv_wd = {wp_z, wp_y, prv_n};

	vbcs_ram #(.WIDTH(96), .DEPTH(ATOM_COUNT)) u_cur (
		.clk   (clk),
		.we    (cur_we),
		.waddr (wa),
		.wdata (cur_wd),
		.raddr (cur_ra),
		.rdata (cur_rd)
	);

	vbcs_ram #(.WIDTH(96), .DEPTH(ATOM_COUNT)) u_prv (
		.clk   (clk),
		.we    (prv_we),
		.waddr (wa),
		.wdata (prv_wd),
		.raddr (AW'(it_q.atom_a)),
		.rdata (prv_rd)
	);

	assign out_load = dc.act == ACT_OUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt2_q     <= 31'd65536;
			damp_q    <= 17'd65536;
			spr_en_q  <= 1'b1;
			hard_en_q <= 1'b1;
			worst_q   <= '0;
			mcnt_q    <= '0;
			scnt_q    <= '0;
			dcnt_q    <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DT2:     dt2_q     <= cfg_data;
					REG_DAMP:    damp_q    <= cfg_data[16:0];
					REG_SPR_EN:  spr_en_q  <= cfg_data[0];
					REG_HARD_EN: hard_en_q <= cfg_data[0];
					default:     dt2_q     <= dt2_q;
				endcase
			end
			if (dc.act == ACT_LATCH && item_d.restart_error)
				worst_q <= '0;
			else if (dc.act == ACT_WORST && devsat > worst_q)
				worst_q <= devsat;
			if (dc.act == ACT_MUL_GO)
				mcnt_q <= 2'd3;
			else if (mcnt_q != 2'd0)
				mcnt_q <= mcnt_q - 2'd1;
			if (dc.act == ACT_SQRT_GO)
				scnt_q <= 6'd32;
			else if (scnt_q != 6'd0)
				scnt_q <= scnt_q - 6'd1;
			if (dc.act == ACT_DIV_GO)
				dcnt_q <= DCW'(DW);
			else if (dcnt_q != '0)
				dcnt_q <= dcnt_q - DCW'(1);
			if (out_load)
				ov_q <= 1'b1;
			else if (result.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (dc.act)
			ACT_LATCH: it_q <= item_d;
			ACT_LD_A: begin
				for (int i = 0; i < 3; i++) begin
					pa_q[i] <= cur_rd[32*i +: 32];
					pv_q[i] <= prv_rd[32*i +: 32];
				end
				acc_q   <= '0;
				moved_q <= 1'b0;
			end
			ACT_LD_B: begin
				for (int i = 0; i < 3; i++) begin
					pb_q[i] <= cur_rd[32*i +: 32];
					if (kind == CMD_HARD)
						d_q[i] <= sat32(50'($signed(cur_rd[32*i +: 32])) - 50'(pa_q[i]));
					else
						d_q[i] <= sat32(50'(pa_q[i]) - 50'($signed(cur_rd[32*i +: 32])));
				end
			end
			ACT_MUL_GO: begin
				ma_q    <= op_a;
				mb_q    <= op_b;
				mneg_q  <= op_neg;
				msh17_q <= op_sh17;
				p_q     <= '0;
			end
			ACT_STEP: begin
				nx_q[dc.lane] <= nxv;
				d_q[dc.lane]  <= dnv;
			end
			ACT_SQ_ACC: acc_q <= acc_q + p_q[63:0];
			ACT_SQRT_GO: begin
				sv_q <= acc_q;
				sr_q <= '0;
				sb_q <= 64'd1 << 62;
			end
			ACT_DIV_GO: begin
				dq_q   <= DW'({nmag, {FRAC_BITS{1'b0}}});
				rem_q  <= '0;
				dv_q   <= len;
				dneg_q <= dnum[32];
			end
			ACT_DIV_TAKE: fac_q <= dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
			ACT_FAC_ONE:  fac_q <= DFW'(ONE);
			ACT_TAKE_KD:  kd_q  <= mres;
			ACT_TAKE_S:   s_q   <= mres;
			ACT_APPLY: begin
				pa_q[dc.lane] <= na;
				pb_q[dc.lane] <= nb;
				if (na != pa_q[dc.lane] || nb != pb_q[dc.lane])
					moved_q <= 1'b1;
			end
			ACT_WR_A: begin
				if (kind == CMD_WRITE || kind == CMD_INT) begin
					pa_q[0] <= wa_x;
					pa_q[1] <= wa_y;
					pa_q[2] <= wa_z;
					if (wa_x != pa_q[0] || wa_y != pa_q[1] || wa_z != pa_q[2] ||
						wp_x != pv_q[0] || wp_y != pv_q[1] || wp_z != pv_q[2])
						moved_q <= 1'b1;
				end
			end
			ACT_OUT: begin
				ox_q  <= a_ok ? pa_q[0] : 32'sd0;
				oy_q  <= a_ok ? pa_q[1] : 32'sd0;
				oz_q  <= a_ok ? pa_q[2] : 32'sd0;
				ome_q <= worst_q;
				omv_q <= moved_q;
			end
			default: ;
		endcase
		if (mcnt_q != 2'd0)
			p_q <= p_q + (96'(pp) << (16 * cidx));
		if (scnt_q != 6'd0) begin
			if (sv_q >= st) begin
				sv_q <= sv_q - st;
				sr_q <= (sr_q >> 1) + sb_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
			sb_q <= sb_q >> 2;
		end
		if (dcnt_q != '0) begin
			if (rsh >= {1'b0, dv_q}) begin
				rem_q <= 32'(rsh - {1'b0, dv_q});
				dq_q  <= {dq_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rsh[31:0];
				dq_q  <= {dq_q[DW-2:0], 1'b0};
			end
		end
	end

	assign sts.kind       = kind;
	assign sts.mul_busy   = mcnt_q != 2'd0;
	assign sts.sqrt_busy  = scnt_q != 6'd0;
	assign sts.div_busy   = dcnt_q != '0;
	assign sts.len_small  = 64'(len) < 64'(THR);
	assign sts.rest_small = 64'(it_q.rest_length) < 64'(THR);
	assign sts.hard_skip  = (64'(devmag) < 64'(TOL)) || (64'(len) < 64'(TOL));
	assign sts.out_free   = !ov_q || result.ready;

	assign result.valid     = ov_q;
	assign result.out_x     = ox_q;
	assign result.out_y     = oy_q;
	assign result.out_z     = oz_q;
	assign result.max_error = ome_q;
	assign result.moved     = omv_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dc.act == ACT_DIV_GO |-> len != 32'd0)
		else $error("division started with zero length");

	a_sqrt_range: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(scnt_q != 6'd0) |-> sr_q[63:32] == 32'd0)
		else $error("square root result exceeds 32 bits");

endmodule

>>> hdl/vbcs_ctrl.sv
module vbcs_ctrl import vbcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	vbcs_item_if.sink item,
	input  dp_sts_t sts,
	output dp_cmd_t dc
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_RDA   = 5'd1;
	localparam logic [4:0] S_LDA   = 5'd2;
	localparam logic [4:0] S_LDB   = 5'd3;
	localparam logic [4:0] S_IMUL  = 5'd4;
	localparam logic [4:0] S_IWAIT = 5'd5;
	localparam logic [4:0] S_SQ    = 5'd6;
	localparam logic [4:0] S_SQW   = 5'd7;
	localparam logic [4:0] S_SQRT  = 5'd8;
	localparam logic [4:0] S_SQRTW = 5'd9;
	localparam logic [4:0] S_DIVG  = 5'd10;
	localparam logic [4:0] S_DIVW  = 5'd11;
	localparam logic [4:0] S_KD    = 5'd12;
	localparam logic [4:0] S_KDW   = 5'd13;
	localparam logic [4:0] S_SMUL  = 5'd14;
	localparam logic [4:0] S_SW    = 5'd15;
	localparam logic [4:0] S_FMUL  = 5'd16;
	localparam logic [4:0] S_FW    = 5'd17;
	localparam logic [4:0] S_WRA   = 5'd18;
	localparam logic [4:0] S_WRB   = 5'd19;
	localparam logic [4:0] S_FIN   = 5'd20;

	logic [4:0] state_q, state_d;
	logic [1:0] lane_q, lane_d;
	logic       pair;

	assign pair       = (sts.kind == CMD_SPRING) || (sts.kind == CMD_HARD);
	assign item.ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		lane_d  = lane_q;
		dc.act  = ACT_NONE;
		dc.lane = lane_q;
		dc.mop  = MOP_STEP;
		unique case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					dc.act  = ACT_LATCH;
					state_d = S_RDA;
				end
			end
			S_RDA: begin
				dc.act  = ACT_RD_A;
				state_d = S_LDA;
			end
			S_LDA: begin
				dc.act  = ACT_LD_A;
				state_d = S_LDB;
			end
			S_LDB: begin
				dc.act = ACT_LD_B;
				lane_d = 2'd0;
				case (sts.kind) inside
					CMD_WRITE:            state_d = S_WRA;
					CMD_INT:              state_d = S_IMUL;
					CMD_SPRING, CMD_HARD: state_d = S_SQ;
					default:              state_d = S_FIN;
				endcase
			end
			S_IMUL: begin
				dc.act  = ACT_MUL_GO;
				dc.mop  = MOP_STEP;
				state_d = S_IWAIT;
			end
			S_IWAIT: begin
				if (!sts.mul_busy) begin
					dc.act = ACT_STEP;
					if (lane_q == 2'd2) begin
						lane_d  = 2'd0;
						state_d = S_SQ;
					end else begin
						lane_d  = lane_q + 2'd1;
						state_d = S_IMUL;
					end
				end
			end
			S_SQ: begin
				dc.act  = ACT_MUL_GO;
				dc.mop  = MOP_SQ;
				state_d = S_SQW;
			end
			S_SQW: begin
				if (!sts.mul_busy) begin
					dc.act = ACT_SQ_ACC;
					if (lane_q == 2'd2) begin
						lane_d  = 2'd0;
						state_d = (sts.kind == CMD_INT) ? S_WRA : S_SQRT;
					end else begin
						lane_d  = lane_q + 2'd1;
						state_d = S_SQ;
					end
				end
			end
			S_SQRT: begin
				dc.act  = ACT_SQRT_GO;
				state_d = S_SQRTW;
			end
			S_SQRTW: begin
				if (!sts.sqrt_busy) begin
					if (sts.kind == CMD_SPRING) begin
						if (!sts.len_small) begin
							state_d = S_DIVG;
						end else if (sts.rest_small) begin
							state_d = S_FIN;
						end else begin
							dc.act  = ACT_FAC_ONE;
							state_d = S_KD;
						end
					end else if (sts.hard_skip) begin
						state_d = S_FIN;
					end else begin
						dc.act  = ACT_WORST;
						state_d = S_DIVG;
					end
				end
			end
			S_DIVG: begin
				dc.act  = ACT_DIV_GO;
				state_d = S_DIVW;
			end
			S_DIVW: begin
				if (!sts.div_busy) begin
					dc.act  = ACT_DIV_TAKE;
					lane_d  = 2'd0;
					state_d = (sts.kind == CMD_SPRING) ? S_KD : S_FMUL;
				end
			end
			S_KD: begin
				dc.act  = ACT_MUL_GO;
				dc.mop  = MOP_KD;
				state_d = S_KDW;
			end
			S_KDW: begin
				if (!sts.mul_busy) begin
					dc.act  = ACT_TAKE_KD;
					state_d = S_SMUL;
				end
			end
			S_SMUL: begin
				dc.act  = ACT_MUL_GO;
				dc.mop  = MOP_S;
				state_d = S_SW;
			end
			S_SW: begin
				if (!sts.mul_busy) begin
					dc.act  = ACT_TAKE_S;
					lane_d  = 2'd0;
					state_d = S_FMUL;
				end
			end
			S_FMUL: begin
				dc.act  = ACT_MUL_GO;
				dc.mop  = MOP_FORCE;
				state_d = S_FW;
			end
			S_FW: begin
				if (!sts.mul_busy) begin
					dc.act = ACT_APPLY;
					if (lane_q == 2'd2) begin
						lane_d  = 2'd0;
						state_d = S_WRA;
					end else begin
						lane_d  = lane_q + 2'd1;
						state_d = S_FMUL;
					end
				end
			end
			S_WRA: begin
				dc.act  = ACT_WR_A;
				state_d = pair ? S_WRB : S_FIN;
			end
			S_WRB: begin
				dc.act  = ACT_WR_B;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					dc.act  = ACT_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lane_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			lane_q  <= lane_d;
		end
	end

	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		dc.act == ACT_MUL_GO |-> !sts.mul_busy)
		else $error("multiplier restarted while busy");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> state_q == S_RDA)
		else $error("accepted transaction did not start a read");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		dc.act == ACT_OUT |-> sts.out_free)
		else $error("result register overwritten");

endmodule

>>> hdl/verlet_bond_constraint_solver_unit.sv
// Position-based bond solver over ATOM_COUNT atoms in signed Q16.16, one transaction at a
// time. A skipped hard pair or a spring whose length is below the threshold takes a
// shorter path, and a finished result waits for the previous one to leave the result
// register. The pair cost is set by the one-bit-per-cycle divider, the square root and a
// 48 by 16 multiplier that sums partial products over the 16-bit slices of one operand.
// Atom positions sit in two 96-bit RAMs (current, previous) with one read and one write
// port each, so the two atoms of a pair are fetched one after the other. A finished
// result waits in an output register while the next transaction is taken. Configuration
// writes apply at once and belong only where no transaction is in flight.
module verlet_bond_constraint_solver_unit import vbcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	vbcs_item_if.sink   item,
	vbcs_result_if.source result
);

	item_t   item_d;
	dp_cmd_t dc;
	dp_sts_t sts;

	assign item_d.cmd           = item.cmd;
	assign item_d.atom_a        = item.atom_a;
	assign item_d.atom_b        = item.atom_b;
	assign item_d.in_x          = item.in_x;
	assign item_d.in_y          = item.in_y;
	assign item_d.in_z          = item.in_z;
	assign item_d.rest_length   = item.rest_length;
	assign item_d.stiffness     = item.stiffness;
	assign item_d.restart_error = item.restart_error;

	vbcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.sts    (sts),
		.dc     (dc)
	);

	vbcs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_d    (item_d),
		.dc        (dc),
		.sts       (sts),
		.result    (result)
	);

endmodule
